// File: sv/dre_pkg.sv
// Shared types and constants for the delimited region extractor.
// No dependencies; imported by every module of the block.
`default_nettype none

package dre_pkg;

  localparam int unsigned MaxDelim = 8;
  localparam int unsigned LenW = 4;
  localparam int unsigned IdxW = 3;
  localparam int unsigned LineW = 32;
  localparam int unsigned CfgW = 64;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [7:0] NewlineChar = 8'h0A;

  localparam logic [1:0] KindPlain = 2'd0;
  localparam logic [1:0] KindMsg = 2'd1;
  localparam logic [1:0] KindEnd = 2'd2;

  localparam logic [CfgIdxW-1:0] RegOpenLen = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOpenBytes = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCloseLen = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCloseBytes = 3'd3;
  localparam logic [CfgIdxW-1:0] RegEmitPlain = 3'd4;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       out_byte;
    logic [LineW-1:0] entry_line;
    logic             run_last;
  } result_t;

endpackage

`default_nettype wire

// File: sv/dre_cmp.sv
// Shared byte select and compare unit of the delimited region extractor.
// Depends on dre_pkg.
`default_nettype none

module dre_cmp (
  input  wire logic [dre_pkg::CfgW-1:0] open_bytes_i,
  input  wire logic [dre_pkg::CfgW-1:0] close_bytes_i,
  input  wire logic                     sel_close_i,
  input  wire logic [dre_pkg::IdxW-1:0] idx_i,
  input  wire logic [7:0]               text_byte_i,
  output logic      [7:0]               sel_byte_o,
  output logic                          eq_o
);
  import dre_pkg::*;

  logic [CfgW-1:0] delim;

  assign delim = sel_close_i ? close_bytes_i : open_bytes_i;
  assign sel_byte_o = delim[{idx_i, 3'b000} +: 8];
  assign eq_o = (sel_byte_o == text_byte_i);

endmodule

`default_nettype wire

// File: sv/dre_out_reg.sv
// Output register of the delimited region extractor: one result slot.
// Depends on dre_pkg.
`default_nettype none

module dre_out_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire dre_pkg::result_t res_i,
  output logic                  free_o,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output dre_pkg::result_t      res_o
);
  import dre_pkg::*;

  logic    valid_q;
  result_t res_q;

  // The slot can take a new result when empty or when it drains this cycle.
  assign free_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && free_o) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

// File: sv/delimited_region_extractor.sv
// Top level of the delimited region extractor: configuration registers,
// sequencer, and the shared compare unit and output register.
// Depends on dre_pkg, dre_cmp and dre_out_reg.
//
// Usage: text bytes enter one per transaction on the text channel
// (text_valid_i / text_ready_o). Each byte yields zero to eight results on
// the output channel (out_valid_o / out_ready_i); run_last_o marks the final
// result caused by a byte. Bytes outside a region come out as plain bytes,
// bytes inside as message bytes, and a completed closing delimiter gives an
// end-of-entry result carrying the newline count taken when the region
// opened. Configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i
// while the block is idle; writes take effect at once.
//
// Timing: the block takes one byte, then works on it alone. A single
// byte-compare unit is visited once per cycle by the sequencer unless a
// stalled receiver holds it, so a byte costs one evaluation, plus one
// replay step per replayed delimiter byte after a broken partial match. A
// completed opening delimiter adds an evaluation; a completed closing
// delimiter adds one, and one more when a plain byte follows its end of entry.
// The first result appears in the output register in the cycle after it is
// produced. A stalled receiver holds the sequencer whenever it has a result
// to hand over; the byte in progress waits. Reset clears the sequencer, the
// match state, the newline count and the configuration to its defaults.
`default_nettype none

module delimited_region_extractor (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [dre_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [dre_pkg::CfgW-1:0]    cfg_wdata_i,
  input  wire logic                        text_valid_i,
  output logic                             text_ready_o,
  input  wire logic [7:0]                  text_byte_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [1:0]                  kind_o,
  output logic      [7:0]                  out_byte_o,
  output logic      [dre_pkg::LineW-1:0]   entry_line_o,
  output logic                             run_last_o
);
  import dre_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_REPLAY
  } state_e;

  typedef enum logic [1:0] {
    PH_NORM  = 2'd0,
    PH_OPEN  = 2'd1,
    PH_MSG   = 2'd2,
    PH_CLOSE = 2'd3
  } phase_e;

  // A length of zero behaves as one, and anything above the maximum as the
  // maximum.
  function automatic logic [LenW-1:0] eff_len(input logic [LenW-1:0] len);
    logic [LenW-1:0] r;
    r = len;
    if (len == '0) begin
      r = LenW'(1);
    end else if (len > LenW'(MaxDelim)) begin
      r = LenW'(MaxDelim);
    end
    return r;
  endfunction

  // Configuration registers.
  logic [LenW-1:0] open_len_q;
  logic [CfgW-1:0] open_bytes_q;
  logic [LenW-1:0] close_len_q;
  logic [CfgW-1:0] close_bytes_q;
  logic            emit_plain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_len_q    <= LenW'(1);
      open_bytes_q  <= '0;
      close_len_q   <= LenW'(1);
      close_bytes_q <= '0;
      emit_plain_q  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegOpenLen:    open_len_q    <= cfg_wdata_i[LenW-1:0];
        RegOpenBytes:  open_bytes_q  <= cfg_wdata_i;
        RegCloseLen:   close_len_q   <= cfg_wdata_i[LenW-1:0];
        RegCloseBytes: close_bytes_q <= cfg_wdata_i;
        RegEmitPlain:  emit_plain_q  <= cfg_wdata_i[0];
        default:       ;
      endcase
    end
  end

  // Sequencer state.
  state_e           state_q, state_d;
  phase_e           phase_q, phase_d;
  logic [LenW-1:0]  mpos_q, mpos_d;
  logic [IdxW-1:0]  rep_i_q, rep_i_d;
  logic [IdxW-1:0]  rep_k_q, rep_k_d;
  logic             silent_q, silent_d;
  logic             end_pend_q, end_pend_d;
  logic [7:0]       b_q, b_d;
  logic [LineW-1:0] nl_q, nl_d;
  logic [LineW-1:0] rline_q, rline_d;

  logic            push;
  result_t         res;
  result_t         res_out;
  logic            slot_free;
  logic [IdxW-1:0] cmp_idx;
  logic [7:0]      cmp_byte;
  logic            cmp_eq;
  logic            rep_end;
  logic            rep_silent;

  // Delimiter choice follows the phase: opening for the two outside phases,
  // closing for the two inside ones. Outside a partial match the position
  // is zero, so the position indexes the delimiter in evaluation.
  assign cmp_idx = (state_q == S_REPLAY) ? rep_i_q : mpos_q[IdxW-1:0];

  dre_cmp u_cmp (
    .open_bytes_i  (open_bytes_q),
    .close_bytes_i (close_bytes_q),
    .sel_close_i   (phase_q[1]),
    .idx_i         (cmp_idx),
    .text_byte_i   (b_q),
    .sel_byte_o    (cmp_byte),
    .eq_o          (cmp_eq)
  );

  // During the first replay cycle the unit compares the held byte with the
  // first delimiter byte; a match means the byte re-examined after the
  // replay gives no result, so the last replayed byte closes the run.
  assign rep_end = (rep_i_q == IdxW'(rep_k_q - IdxW'(1)));
  assign rep_silent = (rep_i_q == '0) ? cmp_eq : silent_q;

  assign text_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    mpos_d     = mpos_q;
    rep_i_d    = rep_i_q;
    rep_k_d    = rep_k_q;
    silent_d   = silent_q;
    end_pend_d = end_pend_q;
    b_d        = b_q;
    nl_d       = nl_q;
    rline_d    = rline_q;
    push       = 1'b0;
    res        = '0;

    unique case (state_q)
      S_IDLE: begin
        if (text_valid_i) begin
          b_d     = text_byte_i;
          nl_d    = (text_byte_i == NewlineChar) ? LineW'(nl_q + LineW'(1)) : nl_q;
          state_d = S_EVAL;
        end
      end

      S_EVAL: begin
        unique case (phase_q)
          PH_NORM: begin
            if (end_pend_q) begin
              // The end-of-entry result is last unless a plain byte follows.
              res.kind       = KindEnd;
              res.entry_line = rline_q;
              res.run_last   = cmp_eq || !emit_plain_q;
              if (slot_free) begin
                push       = 1'b1;
                end_pend_d = 1'b0;
                if (cmp_eq) begin
                  phase_d = PH_OPEN;
                  mpos_d  = LenW'(1);
                  state_d = S_IDLE;
                end else if (!emit_plain_q) begin
                  state_d = S_IDLE;
                end
              end
            end else if (cmp_eq) begin
              phase_d = PH_OPEN;
              mpos_d  = LenW'(1);
              state_d = S_IDLE;
            end else if (emit_plain_q) begin
              res.kind     = KindPlain;
              res.out_byte = b_q;
              res.run_last = 1'b1;
              if (slot_free) begin
                push    = 1'b1;
                state_d = S_IDLE;
              end
            end else begin
              state_d = S_IDLE;
            end
          end

          PH_OPEN: begin
            if (mpos_q >= eff_len(open_len_q)) begin
              phase_d = PH_MSG;
              mpos_d  = '0;
              rline_d = nl_q;
            end else if (!cmp_eq) begin
              phase_d = PH_NORM;
              mpos_d  = '0;
              if (emit_plain_q) begin
                rep_k_d = mpos_q[IdxW-1:0];
                rep_i_d = '0;
                state_d = S_REPLAY;
              end else begin
                state_d = S_IDLE;
              end
            end else begin
              mpos_d  = LenW'(mpos_q + LenW'(1));
              state_d = S_IDLE;
            end
          end

          PH_MSG: begin
            if (cmp_eq) begin
              phase_d = PH_CLOSE;
              mpos_d  = LenW'(1);
              state_d = S_IDLE;
            end else begin
              res.kind       = KindMsg;
              res.out_byte   = b_q;
              res.entry_line = rline_q;
              res.run_last   = 1'b1;
              if (slot_free) begin
                push    = 1'b1;
                state_d = S_IDLE;
              end
            end
          end

          PH_CLOSE: begin
            if (mpos_q >= eff_len(close_len_q)) begin
              phase_d    = PH_NORM;
              mpos_d     = '0;
              end_pend_d = 1'b1;
            end else if (!cmp_eq) begin
              phase_d = PH_MSG;
              mpos_d  = '0;
              rep_k_d = mpos_q[IdxW-1:0];
              rep_i_d = '0;
              state_d = S_REPLAY;
            end else begin
              mpos_d  = LenW'(mpos_q + LenW'(1));
              state_d = S_IDLE;
            end
          end

          default: begin
            state_d = S_IDLE;
          end
        endcase
      end

      S_REPLAY: begin
        res.out_byte = cmp_byte;
        res.run_last = rep_end && rep_silent;
        if (phase_q == PH_NORM) begin
          res.kind = KindPlain;
        end else begin
          res.kind       = KindMsg;
          res.entry_line = rline_q;
        end
        if (slot_free) begin
          push = 1'b1;
          if (rep_i_q == '0) begin
            silent_d = cmp_eq;
          end
          if (rep_end) begin
            state_d = S_EVAL;
          end else begin
            rep_i_d = IdxW'(rep_i_q + IdxW'(1));
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      phase_q    <= PH_NORM;
      mpos_q     <= '0;
      rep_i_q    <= '0;
      rep_k_q    <= '0;
      silent_q   <= 1'b0;
      end_pend_q <= 1'b0;
      b_q        <= '0;
      nl_q       <= '0;
      rline_q    <= '0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      mpos_q     <= mpos_d;
      rep_i_q    <= rep_i_d;
      rep_k_q    <= rep_k_d;
      silent_q   <= silent_d;
      end_pend_q <= end_pend_d;
      b_q        <= b_d;
      nl_q       <= nl_d;
      rline_q    <= rline_d;
    end
  end

  dre_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res_i   (res),
    .free_o  (slot_free),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .res_o   (res_out)
  );

  assign kind_o       = res_out.kind;
  assign out_byte_o   = res_out.out_byte;
  assign entry_line_o = res_out.entry_line;
  assign run_last_o   = res_out.run_last;

`ifndef NO_ASSERTIONS
  // A result is only handed over when the output slot can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> slot_free)
    else $error("result pushed into a full output slot");

  // A replay always covers at least one byte and stays within its count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REPLAY) |-> (rep_k_q != '0) && (rep_i_q < rep_k_q))
    else $error("replay counter out of range");

  // The match position never runs past the longest delimiter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mpos_q <= LenW'(MaxDelim))
    else $error("match position beyond maximum delimiter length");

  // A pending end of entry only exists while evaluating outside a region.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_pend_q |-> (phase_q == PH_NORM) && (state_q == S_EVAL))
    else $error("end of entry pending outside evaluation");
`endif

endmodule

`default_nettype wire

// File: tb/delimited_region_extractor_tb.sv
// Self-checking testbench for delimited_region_extractor: directed and random text
// streams, checked result by result against a scoreboard that tracks the region state.
// Depends on dre_pkg and the delimited_region_extractor RTL.
`default_nettype none

module delimited_region_extractor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dre_pkg::*;

  localparam int unsigned ResetCycles = 10;
  // A byte that causes no result still keeps the block busy after it is
  // accepted; this wait covers that tail with ample margin.
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned MaxResults = 8;
  localparam int unsigned PhaseItems = 20;

  // Where the scanner stands between two text bytes.
  typedef enum logic [1:0] {
    PhText,
    PhOpen,
    PhMsg,
    PhClose
  } scan_phase_e;

  // Tracks the scanner state and the configuration registers, works out the
  // results that every accepted text byte causes, and checks the results that
  // the block hands over against them in order.
  class region_scoreboard;
    logic [LenW-1:0]  open_len_r;
    logic [LenW-1:0]  close_len_r;
    logic [CfgW-1:0]  open_r;
    logic [CfgW-1:0]  close_r;
    logic             emit_r;
    scan_phase_e      ph;
    int unsigned      pos;
    logic [LineW-1:0] newline_cnt;
    logic [LineW-1:0] region_line;
    result_t          pending_q[$];
    result_t          step_q[$];
    int unsigned      errors;
    int unsigned      kind_seen[4];

    function new();
      open_len_r = 1;
      close_len_r = 1;
      open_r = '0;
      close_r = '0;
      emit_r = 1'b1;
      ph = PhText;
      pos = 0;
      newline_cnt = '0;
      region_line = '0;
      errors = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
      case (idx)
        RegOpenLen:    open_len_r = data[LenW-1:0];
        RegOpenBytes:  open_r = data;
        RegCloseLen:   close_len_r = data[LenW-1:0];
        RegCloseBytes: close_r = data;
        RegEmitPlain:  emit_r = data[0];
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return pending_q.size();
    endfunction

    function int unsigned clamp_len(logic [LenW-1:0] len);
      if (len == 0) return 1;
      if (len > MaxDelim) return MaxDelim;
      return len;
    endfunction

    function logic [7:0] delim_at(logic [CfgW-1:0] bytes, int unsigned idx);
      return bytes[(idx % 8) * 8 +: 8];
    endfunction

    function void add_result(logic [1:0] kind, logic [7:0] value, logic [LineW-1:0] line);
      result_t r;
      if (step_q.size() >= MaxResults) return;
      r.kind = kind;
      r.out_byte = value;
      r.entry_line = line;
      r.run_last = 1'b0;
      step_q.push_back(r);
    endfunction

    // One accepted text byte. A byte may be examined more than once: after a
    // completed delimiter, and after a broken partial match.
    function void note_text_byte(logic [7:0] b);
      bit          done;
      int unsigned k;
      int unsigned i;
      result_t     r;
      done = 1'b0;
      step_q.delete();
      if (b == NewlineChar) newline_cnt = newline_cnt + 1'b1;
      while (!done) begin
        case (ph)
          PhText: begin
            if (b == delim_at(open_r, 0)) begin
              ph = PhOpen;
              pos = 1;
            end else if (emit_r) begin
              add_result(KindPlain, b, '0);
            end
            done = 1'b1;
          end
          PhOpen: begin
            if (pos >= clamp_len(open_len_r)) begin
              ph = PhMsg;
              pos = 0;
              region_line = newline_cnt;
            end else if (b != delim_at(open_r, pos)) begin
              k = pos;
              ph = PhText;
              pos = 0;
              if (emit_r) begin
                for (i = 0; i < k; i++) add_result(KindPlain, delim_at(open_r, i), '0);
              end else begin
                done = 1'b1;
              end
            end else begin
              pos++;
              done = 1'b1;
            end
          end
          PhMsg: begin
            if (b == delim_at(close_r, 0)) begin
              ph = PhClose;
              pos = 1;
            end else begin
              add_result(KindMsg, b, region_line);
            end
            done = 1'b1;
          end
          default: begin
            if (pos >= clamp_len(close_len_r)) begin
              ph = PhText;
              pos = 0;
              add_result(KindEnd, 8'h00, region_line);
            end else if (b != delim_at(close_r, pos)) begin
              k = pos;
              for (i = 0; i < k; i++) add_result(KindMsg, delim_at(close_r, i), region_line);
              ph = PhMsg;
              pos = 0;
            end else begin
              pos++;
              done = 1'b1;
            end
          end
        endcase
      end
      if (step_q.size() != 0) begin
        r = step_q.pop_back();
        r.run_last = 1'b1;
        step_q.push_back(r);
      end
      foreach (step_q[j]) pending_q.push_back(step_q[j]);
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(logic [1:0] kind, logic [7:0] value, logic [LineW-1:0] line,
                      logic last);
      result_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("result with nothing expected: kind %0d byte %02h line %0d",
                         kind, value, line));
        return;
      end
      want = pending_q.pop_front();
      kind_seen[want.kind]++;
      if (kind !== want.kind || value !== want.out_byte || line !== want.entry_line ||
          last !== want.run_last) begin
        report($sformatf("got kind %0d byte %02h line %0d last %0b, want %0d %02h %0d %0b",
                         kind, value, line, last, want.kind, want.out_byte,
                         want.entry_line, want.run_last));
      end
    endtask

    task check_drained();
      if (pending_q.size() != 0)
        report($sformatf("%0d expected results never arrived", pending_q.size()));
    endtask
  endclass

  // Every input of the block has a known value from time zero.
  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgW-1:0]    cfg_wdata = '0;
  logic               text_valid = 1'b0;
  logic [7:0]         text_byte = '0;
  logic               out_ready = 1'b0;
  logic               rx_hold = 1'b0;

  logic               text_ready;
  logic               out_valid;
  logic [1:0]         kind;
  logic [7:0]         out_byte;
  logic [LineW-1:0]   entry_line;
  logic               run_last;

  region_scoreboard   sb;
  int unsigned        send_idle_pct = 0;
  int unsigned        recv_stall_pct = 0;
  int unsigned        items_sent = 0;
  int unsigned        quiet_cycles = 0;

  // Delimiters as currently configured, with the lengths the block acts on.
  // The stimulus uses them to build well-formed entries.
  logic [CfgW-1:0]    open_d = '0;
  logic [CfgW-1:0]    close_d = '0;
  int unsigned        open_n = 1;
  int unsigned        close_n = 1;

  always #10 clk_i = ~clk_i;

  delimited_region_extractor DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .text_valid_i (text_valid),
    .text_ready_o (text_ready),
    .text_byte_i  (text_byte),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .kind_o       (kind),
    .out_byte_o   (out_byte),
    .entry_line_o (entry_line),
    .run_last_o   (run_last)
  );

  // The receiver stalls at random at the rate of the current phase, and not at
  // all for stretches where the rate is zero. A hold-off overrides it.
  always @(posedge clk_i) begin
    out_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // Both channels are sampled at the clock edge, before any nonblocking update
  // of that edge lands, so a transaction is seen exactly when it happens.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) sb.check_result(kind, out_byte, entry_line, run_last);
      if (text_valid && text_ready) sb.note_text_byte(text_byte);
    end
  end

  // The watchdog ends a run in which no transaction happens for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (text_valid && text_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("[%0t] no transaction for %0d cycles", $time, WatchdogLimit);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one byte and returns at the edge that accepts it. A gap, if one is
  // drawn, comes before valid rises; valid is never dropped while waiting.
  task automatic send_byte(logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      text_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    text_valid <= 1'b1;
    text_byte <= b;
    do @(posedge clk_i); while (text_ready !== 1'b1);
    items_sent++;
  endtask

  task automatic send_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Sends the first n bytes of a delimiter.
  task automatic send_delim(logic [CfgW-1:0] bytes, int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) send_byte(bytes[i * 8 +: 8]);
  endtask

  // Filler text around and inside entries: letters, newlines, arbitrary bytes,
  // partial delimiters that break, stray first bytes of the other delimiter,
  // and the byte extremes.
  task automatic filler(int unsigned n, bit in_region);
    int unsigned     j;
    int unsigned     r;
    logic [CfgW-1:0] d;
    int unsigned     dn;
    d = in_region ? close_d : open_d;
    dn = in_region ? close_n : open_n;
    for (j = 0; j < n; j++) begin
      r = $urandom_range(99);
      if (r < 45) send_byte(8'($urandom_range(8'h7a, 8'h61)));
      else if (r < 55) send_byte(NewlineChar);
      else if (r < 70) send_byte(8'($urandom_range(255)));
      else if (r < 82 && dn > 1) send_delim(d, $urandom_range(dn - 1, 1));
      else if (r < 90) send_byte(in_region ? open_d[7:0] : close_d[7:0]);
      else send_byte(r[0] ? 8'hFF : 8'h00);
    end
  endtask

  // Mostly complete entries with random content; the rest are opening
  // delimiters cut short (or complete ones left hanging) and plain noise.
  task automatic run_random(int unsigned count);
    int unsigned target;
    int unsigned r;
    target = items_sent + count;
    while (items_sent < target) begin
      r = $urandom_range(9);
      if (r < 7) begin
        filler($urandom_range(4, 0), 1'b0);
        send_delim(open_d, open_n);
        filler($urandom_range(5, 0), 1'b1);
        send_delim(close_d, close_n);
      end else if (r < 9) begin
        send_delim(open_d, $urandom_range(open_n, 1));
        filler($urandom_range(3, 1), 1'b0);
      end else begin
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
      end
    end
  endtask

  // Stops offering bytes, waits for the next edge so that the last accepted byte
  // is noted, then for every expected result and for the tail of the work on a
  // byte that causes no result.
  task automatic settle();
    text_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(logic [LenW-1:0] ol, logic [CfgW-1:0] ob, logic [LenW-1:0] cl,
                           logic [CfgW-1:0] cb, logic emit);
    cfg_write(RegOpenLen, CfgW'(ol));
    cfg_write(RegOpenBytes, ob);
    cfg_write(RegCloseLen, CfgW'(cl));
    cfg_write(RegCloseBytes, cb);
    cfg_write(RegEmitPlain, CfgW'(emit));
    open_d = ob;
    close_d = cb;
    open_n = (ol == 0) ? 1 : ((ol > MaxDelim) ? MaxDelim : ol);
    close_n = (cl == 0) ? 1 : ((cl > MaxDelim) ? MaxDelim : cl);
  endtask

  initial begin
    sb = new();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset configuration: both delimiters are a single zero byte. A newline
    // completes the opening, so it counts in the line of its own region; a
    // zero right after the close completes the entry and opens the next one.
    send_byte(8'h41); send_byte(8'hFF); send_byte(8'h00); send_byte(NewlineChar);
    send_byte(8'h00); send_byte(8'h00); send_byte(8'h7E); send_byte(8'h00);
    send_byte(8'h41);
    settle();

    // Writes to indexes past the last register must change nothing.
    for (int i = RegEmitPlain + 1; i < (1 << CfgIdxW); i++)
      cfg_write(CfgIdxW'(i), {$urandom, $urandom});

    // Opening "<{[" and closing "]}": a broken opening replays its prefix as
    // plain text, a broken closing replays as message text, and the byte after
    // a complete closing comes out as plain text behind the end of entry.
    configure(4'd3, 64'h5B7B3C, 4'd2, 64'h7D5D, 1'b1);
    send_text("<{x<{[\nm]x]}z");
    settle();

    // Plain output off: the byte breaking an opening match is dropped. The
    // stream stops one byte into the closing delimiter, which is then cut to
    // one byte, so the next byte finds the close already complete.
    configure(4'd2, 64'h7B3C, 4'd2, 64'h7D5D, 1'b0);
    send_text("<x<{m]");
    settle();
    cfg_write(RegCloseLen, CfgW'(1));
    send_byte(8'h21);
    settle();

    // Longest delimiters with arbitrary bytes, no idling on either side.
    configure(4'd8, {$urandom, $urandom}, 4'd8, {$urandom, $urandom}, 1'b1);
    run_random(PhaseItems);
    settle();

    // Single-byte delimiters, the opening one all ones; sparse sender.
    send_idle_pct = 82;
    configure(4'd1, '1, 4'd1, {$urandom, $urandom}, 1'b1);
    run_random(PhaseItems);
    settle();

    // Lengths out of range (zero and fifteen), plain output off; the receiver
    // stalls most of the time.
    send_idle_pct = 0;
    recv_stall_pct = 82;
    configure(4'd0, {$urandom, $urandom}, 4'd15, {$urandom, $urandom}, 1'b0);
    run_random(PhaseItems);
    settle();

    // Moderate idling on both sides, with the sender pausing half way until
    // the block has handed over everything it owes.
    send_idle_pct = 28;
    recv_stall_pct = 28;
    configure(4'($urandom_range(8, 1)), {$urandom, $urandom}, 4'($urandom_range(8, 1)),
              {$urandom, $urandom}, 1'b1);
    run_random(PhaseItems / 2);
    settle();
    run_random(PhaseItems / 2);
    settle();

    // The receiver holds off for a long stretch while the sender keeps
    // offering bytes, so the block fills up and stops taking input.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    configure(4'($urandom_range(8, 2)), {$urandom, $urandom}, 4'($urandom_range(8, 2)),
              {$urandom, $urandom}, 1'b1);
    fork
      begin
        rx_hold <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk_i);
        rx_hold <= 1'b0;
      end
      run_random(PhaseItems);
    join
    settle();

    sb.check_drained();
    $display("Sent %0d text bytes: a directed part, then random phases with sender gaps,",
             items_sent);
    $display("receiver stalls and a %0d-cycle hold-off; %0d plain, %0d message, %0d end results.",
             HoldOffCycles, sb.kind_seen[KindPlain], sb.kind_seen[KindMsg],
             sb.kind_seen[KindEnd]);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
